>>> rtl/goto_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Goto packet deframer assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef GOTO_PACKET_DEFRAMER_DEFINES_SVH
`define GOTO_PACKET_DEFRAMER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define GPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/gpd_pkg.sv
// ----------------------------------------------------------------------------
// Goto packet deframer package
// Word types, event codes and framing constants.
// ----------------------------------------------------------------------------
package gpd_pkg;

   typedef enum logic [1:0] {
      EV_GOTO       = 2'd0,
      EV_BAD_SIZE   = 2'd1,
      EV_SHORT_GOTO = 2'd2,
      EV_IGNORED    = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [7:0]         rx_byte;
      logic signed [63:0] now_time;
   } req_payload_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic [31:0]        right_ascension;
      logic signed [31:0] declination;
      logic signed [63:0] time_offset;
      logic [15:0]        packet_type;
      logic [15:0]        packet_size;
   } rsp_payload_type;

   // Framing layout (byte positions within a packet)
   localparam int unsigned POS_LEN_LO   = 0;
   localparam int unsigned POS_LEN_HI   = 1;
   localparam int unsigned POS_TYPE_LO  = 2;
   localparam int unsigned POS_TYPE_HI  = 3;
   localparam int unsigned POS_TIME     = 4;
   localparam int unsigned POS_RA       = 12;
   localparam int unsigned POS_DEC      = 16;
   localparam int unsigned POS_FIELDS_END = 20;

   localparam logic [15:0] MIN_LEN      = 16'd4;
   localparam logic [15:0] GOTO_MIN_LEN = 16'd20;
   localparam logic [15:0] GOTO_TYPE    = 16'd0;

   localparam logic signed [63:0] OFFSET_RESET = 64'sh7FFF_FFFF_FFFF_FFFF;

endpackage

>>> rtl/gpd_stream_if.sv
// ----------------------------------------------------------------------------
// Goto packet deframer stream channel
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface gpd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/gpd_parser.sv
// ----------------------------------------------------------------------------
// Goto packet deframer parser
// Framing state and per-byte field decode; yields at most one result per byte.
// ----------------------------------------------------------------------------
module gpd_parser #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  gpd_pkg::req_payload_type item,
   output logic                     result_valid,
   output gpd_pkg::rsp_payload_type result
);
   import gpd_pkg::*;

   // Position counter must also hold position + 1 up to MAX_PACKET
   localparam int unsigned PosW = $clog2(MAX_PACKET + 1);

   logic               hung_ff, hung_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [15:0]        len_ff, len_in;
   logic [15:0]        type_ff, type_in;
   logic [63:0]        ctime_ff, ctime_in;
   logic [31:0]        ra_ff, ra_in;
   logic [31:0]        dec_ff, dec_in;
   logic signed [63:0] offset_ff, offset_in;

   logic [PosW-1:0]    pos_plus;
   logic [PosW-1:0]    rel_time;
   logic [PosW-1:0]    rel_ra;
   logic [PosW-1:0]    rel_dec;
   logic               done;

   assign pos_plus = pos_ff + PosW'(1);
   assign rel_time = pos_ff - PosW'(POS_TIME);
   assign rel_ra   = pos_ff - PosW'(POS_RA);
   assign rel_dec  = pos_ff - PosW'(POS_DEC);

   always_comb begin
      hung_in      = hung_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      ctime_in     = ctime_ff;
      ra_in        = ra_ff;
      dec_in       = dec_ff;
      offset_in    = offset_ff;
      done         = 1'b0;
      result_valid = 1'b0;
      result       = '{event_kind: EV_IGNORED, right_ascension: '0, declination: '0,
                       time_offset: offset_ff, packet_type: '0, packet_size: '0};

      if (step_valid && !hung_ff) begin
         // Field capture for this byte
         if (pos_ff == PosW'(POS_LEN_LO)) begin
            len_in = {8'h00, item.rx_byte};
         end else if (pos_ff == PosW'(POS_LEN_HI)) begin
            len_in = {item.rx_byte, len_ff[7:0]};
         end else if (pos_ff == PosW'(POS_TYPE_LO)) begin
            type_in = {8'h00, item.rx_byte};
         end else if (pos_ff == PosW'(POS_TYPE_HI)) begin
            type_in = {item.rx_byte, type_ff[7:0]};
         end else if (pos_ff < PosW'(POS_RA)) begin
            ctime_in[rel_time[2:0]*8 +: 8] = item.rx_byte;
         end else if (pos_ff < PosW'(POS_DEC)) begin
            ra_in[rel_ra[1:0]*8 +: 8] = item.rx_byte;
         end else if (pos_ff < PosW'(POS_FIELDS_END)) begin
            dec_in[rel_dec[1:0]*8 +: 8] = item.rx_byte;
         end

         done = (pos_plus >= PosW'(2)) && (16'(pos_plus) >= len_in);

         if (pos_ff == PosW'(POS_LEN_HI) &&
             (len_in > 16'(MAX_PACKET) || len_in < MIN_LEN)) begin
            // Bad length: hang up for good
            hung_in            = 1'b1;
            pos_in             = '0;
            result_valid       = 1'b1;
            result.event_kind  = EV_BAD_SIZE;
            result.packet_size = len_in;
         end else if (done) begin
            pos_in             = '0;
            result_valid       = 1'b1;
            result.packet_type = type_in;
            result.packet_size = len_in;
            if (type_in == GOTO_TYPE) begin
               if (len_in < GOTO_MIN_LEN) begin
                  hung_in           = 1'b1;
                  result.event_kind = EV_SHORT_GOTO;
               end else begin
                  offset_in              = item.now_time - $signed(ctime_in);
                  result.event_kind      = EV_GOTO;
                  result.right_ascension = ra_in;
                  result.declination     = $signed(dec_in);
                  result.time_offset     = offset_in;
               end
            end else begin
               result.event_kind = EV_IGNORED;
            end
         end else begin
            pos_in = pos_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hung_ff   <= 1'b0;
         pos_ff    <= '0;
         len_ff    <= '0;
         type_ff   <= '0;
         ctime_ff  <= '0;
         ra_ff     <= '0;
         dec_ff    <= '0;
         offset_ff <= OFFSET_RESET;
      end else begin
         hung_ff   <= hung_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         type_ff   <= type_in;
         ctime_ff  <= ctime_in;
         ra_ff     <= ra_in;
         dec_ff    <= dec_in;
         offset_ff <= offset_in;
      end
   end

endmodule

>>> rtl/goto_packet_deframer.sv
// ----------------------------------------------------------------------------
// Goto packet deframer
// Splits a received byte stream into length/type framed packets and reports
// goto requests, size errors, short goto packets and ignored packets.
// ----------------------------------------------------------------------------
//
//   channel   modport  payload                     word
//   -------   -------  --------------------------  -----------------------------
//   req_chan  sink     gpd_pkg::req_payload_type   one stream byte + server time
//   rsp_chan  source   gpd_pkg::rsp_payload_type   one packet event
//
// One byte is taken every cycle while the result side keeps up; a byte's
// event passes from the input register through the parser into the result
// register before it shows on rsp_chan.
// A stalled result holds the parser and input register; req_chan.ready then
// drops only once the input register is also full.
// Reset is synchronous and clears framing state; the stored time offset
// returns to its largest positive value.
// After a size error or a short goto packet every byte is taken and dropped
// until reset.
// ----------------------------------------------------------------------------
module goto_packet_deframer #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  logic         clock,
   input  logic         reset,
   gpd_stream_if.sink   req_chan,
   gpd_stream_if.source rsp_chan
);
   import gpd_pkg::*;

   // Input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_word_ff;

   // Result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_word_ff;

   logic            out_free;
   logic            step;
   logic            req_take;
   logic            res_valid;
   rsp_payload_type res_word;

   // Advance the input word into the parser whenever the result slot can take
   // whatever it produces.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   gpd_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step),
      .item         (in_word_ff),
      .result_valid (res_valid),
      .result       (res_word)
   );

   always_comb begin
      // Hold the input word until the parser consumes it
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // Load a fresh event, drop a delivered one, otherwise hold
      if (step && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_chan.payload;
      end
      if (step && res_valid) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

endmodule

>>> rtl/gpd_checker.sv
// ----------------------------------------------------------------------------
// Goto packet deframer checker
// Port-level checks on the event channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "goto_packet_deframer_defines.svh"

module gpd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input gpd_pkg::rsp_payload_type rsp_payload
);
   import gpd_pkg::*;

   `GPD_ASSERT_ALWAYS(a_no_event_after_reset, clock, reset |=> !rsp_valid, "event right after reset")

   `GPD_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled event word changed")

   `GPD_ASSERT(a_hangup_silent, clock, reset, rsp_valid && rsp_ready && (rsp_payload.event_kind == EV_BAD_SIZE || rsp_payload.event_kind == EV_SHORT_GOTO) |=> !rsp_valid, "event after hang-up")

   `GPD_ASSERT(a_position_only_goto, clock, reset, rsp_valid && rsp_payload.event_kind != EV_GOTO |-> rsp_payload.right_ascension == 32'd0 && rsp_payload.declination == 32'sd0, "position on a non-goto event")

   `GPD_ASSERT(a_bad_size_no_type, clock, reset, rsp_valid && rsp_payload.event_kind == EV_BAD_SIZE |-> rsp_payload.packet_type == 16'd0, "type on a size error")

endmodule

bind goto_packet_deframer gpd_checker u_gpd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Goto packet deframer testbench
// Streams framed packets into the deframer one byte per word, with random
// gaps on both channels, and checks every packet event against a local
// deframing predictor. The run ends on a single terminal framing error that
// latches the hung-up state, so the bytes that follow must produce nothing.
// ----------------------------------------------------------------------------
module tb;
   import gpd_pkg::*;

   localparam int unsigned MAX_PACKET  = 128;
   localparam int unsigned TARGET_BYTES = 900;
   localparam int unsigned TAIL_BYTES  = 120;   // no idling once this few remain
   localparam int unsigned HOLD_CYCLES = 64;    // long result stall
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 100000;

   typedef struct packed {
      req_payload_type word;
      bit              settle;   // wait for all events before offering this byte
   } stream_item_type;

   logic clock;
   logic reset;

   gpd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   gpd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   goto_packet_deframer #(
      .MAX_PACKET(MAX_PACKET)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Bytes still to send, and packet events predicted but not yet seen.
   stream_item_type stream_bytes[$];
   rsp_payload_type predicted_events[$];

   int unsigned failures = 0;
   int unsigned cycles = 0;
   int unsigned bytes_accepted = 0;
   bit          req_taken = 1'b0;
   bit          calm = 1'b0;
   bit          hold_off = 1'b0;
   int unsigned src_gap = 0;
   int unsigned snk_gap = 0;

   // Predictor copy of the framing state.
   bit                 hung = 1'b0;
   logic [15:0]        frame_pos = '0;
   logic [15:0]        frame_len = '0;
   logic [15:0]        frame_type = '0;
   logic [63:0]        client_time = '0;
   logic [31:0]        goto_ra = '0;
   logic [31:0]        goto_dec = '0;
   logic signed [63:0] clock_offset = OFFSET_RESET;

   // ------------------------------------------------------------------------
   // Clock: 20 ns period.
   // ------------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Predictor: advance the framing state by one byte and queue the event
   // that the byte completes, if any.
   // ------------------------------------------------------------------------
   task automatic deframe_byte(input logic [7:0] rx, input logic signed [63:0] now);
      logic [15:0]     next_pos;
      rsp_payload_type ev;
      // Once hung up, drop everything until reset.
      if (hung) return;
      ev = '0;
      ev.time_offset = clock_offset;
      case (frame_pos)
         POS_LEN_LO: frame_len = {8'h00, rx};
         POS_LEN_HI: begin
            frame_len[15:8] = rx;
            // Reject the length as soon as it is complete.
            if (frame_len > MAX_PACKET || frame_len < MIN_LEN) begin
               hung = 1'b1;
               frame_pos = '0;
               ev.event_kind = EV_BAD_SIZE;
               ev.packet_size = frame_len;
               predicted_events.push_back(ev);
               return;
            end
         end
         POS_TYPE_LO: frame_type = {8'h00, rx};
         POS_TYPE_HI: frame_type[15:8] = rx;
         default: begin
            // Field bytes land whatever the type; trailing bytes are skipped.
            if (frame_pos < POS_RA)
               client_time[8 * (frame_pos - POS_TIME) +: 8] = rx;
            else if (frame_pos < POS_DEC)
               goto_ra[8 * (frame_pos - POS_RA) +: 8] = rx;
            else if (frame_pos < POS_FIELDS_END)
               goto_dec[8 * (frame_pos - POS_DEC) +: 8] = rx;
         end
      endcase

      next_pos = frame_pos + 16'd1;
      if (next_pos < 16'd2 || next_pos < frame_len) begin
         frame_pos = next_pos;
         return;
      end

      // Packet complete.
      frame_pos = '0;
      ev.packet_type = frame_type;
      ev.packet_size = frame_len;
      if (frame_type != GOTO_TYPE) begin
         ev.event_kind = EV_IGNORED;
      end else if (frame_len < GOTO_MIN_LEN) begin
         // Goto too short to hold its fields: latch the hang-up, keep the offset.
         hung = 1'b1;
         ev.event_kind = EV_SHORT_GOTO;
      end else begin
         // Offset uses the server time of the closing byte.
         clock_offset = now - client_time;
         ev.event_kind = EV_GOTO;
         ev.right_ascension = goto_ra;
         ev.declination = goto_dec;
         ev.time_offset = clock_offset;
      end
      predicted_events.push_back(ev);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus builders.
   // ------------------------------------------------------------------------
   function automatic logic [31:0] edgy32();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] rx, input logic signed [63:0] now,
                            input bit settle);
      stream_item_type item;
      item.word.rx_byte = rx;
      item.word.now_time = now;
      item.settle = settle;
      stream_bytes.push_back(item);
   endtask

   // Queue one packet; a rejected length stops after its two length bytes.
   task automatic add_packet(input logic [15:0] len, input logic [15:0] kind,
                             input logic [63:0] ctime, input logic [31:0] ra,
                             input logic [31:0] dec, input bit settle);
      logic [159:0]       fields;
      int unsigned        count;
      bit                 near;
      logic signed [63:0] now;
      fields = {dec, ra, ctime, kind, len};
      count = (len < MIN_LEN || len > MAX_PACKET) ? 2 : len;
      near = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < count; i++) begin
         // Half the packets keep server time close to client time.
         if (near)
            now = ctime + 64'($urandom_range(0, 2000)) - 64'd1000;
         else
            now = {$urandom, $urandom};
         push_byte((i < POS_FIELDS_END) ? fields[8 * i +: 8] : 8'($urandom),
                   now, settle && i == 0);
      end
   endtask

   task automatic add_random_packet(input bit settle);
      logic [15:0] len;
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 7) begin
         // Goto: mostly minimum size with a few trailing bytes, rarely the largest.
         if (pick == 0) len = 16'(MAX_PACKET);
         else if (pick == 1) len = 16'($urandom_range(21, MAX_PACKET - 1));
         else len = 16'($urandom_range(20, 26));
         add_packet(len, GOTO_TYPE, {edgy32(), edgy32()}, edgy32(), edgy32(), settle);
      end else begin
         if (pick == 0) len = 16'(MAX_PACKET);
         else if (pick == 1) len = 16'($urandom_range(5, MAX_PACKET - 1));
         else len = 16'($urandom_range(4, 10));
         add_packet(len, 16'($urandom_range(1, 65535)), {$urandom, $urandom},
                    $urandom, $urandom, settle);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: offer bytes at the falling edge; hold a byte until taken.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      stream_item_type item;
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (stream_bytes.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (stream_bytes[0].settle && predicted_events.size() != 0) begin
            // Pause the sender until every event has come back.
            req_chan.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            src_gap <= $urandom_range(0, 2);
            req_chan.valid <= 1'b0;
         end else begin
            item = stream_bytes.pop_front();
            req_chan.payload <= item.word;
            req_chan.valid <= 1'b1;
         end
      end
      calm <= (stream_bytes.size() < TAIL_BYTES);
   end

   // ------------------------------------------------------------------------
   // Result side ready: random bursts of stall, plus the long hold-off.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else if (snk_gap > 0) begin
         snk_gap <= snk_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         snk_gap <= $urandom_range(0, 2);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Hold off the result side long enough to back up the input.
   initial begin
      while (bytes_accepted < 300) @(posedge clock);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted byte, check each accepted event.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            bytes_accepted++;
            deframe_byte(req_chan.payload.rx_byte, req_chan.payload.now_time);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (predicted_events.size() == 0) begin
               $error("event_kind: no event expected, got %0d", got.event_kind);
               failures++;
            end else begin
               want = predicted_events.pop_front();
               check_field("event_kind", want.event_kind, got.event_kind);
               check_field("right_ascension", want.right_ascension, got.right_ascension);
               check_field("declination", want.declination, got.declination);
               check_field("time_offset", want.time_offset, got.time_offset);
               check_field("packet_type", want.packet_type, got.packet_type);
               check_field("packet_size", want.packet_size, got.packet_size);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ------------------------------------------------------------------------
   initial begin
      bit settle_done;
      int unsigned ending;
      logic [15:0] bad_len;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      settle_done = 1'b0;

      // Directed: smallest ignored packet first so the reset offset shows,
      // then a minimum goto with extreme field values.
      add_packet(MIN_LEN, 16'hFFFF, '0, '0, '0, 1'b0);
      add_packet(GOTO_MIN_LEN, GOTO_TYPE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000, 1'b0);

      // Random well-formed traffic, with one drain pause in the middle.
      while (stream_bytes.size() < TARGET_BYTES) begin
         add_random_packet(!settle_done && stream_bytes.size() >= 550);
         if (stream_bytes.size() >= 550) settle_done = 1'b1;
      end

      // Finish on one framing error; the hang-up lasts until reset, so only one.
      ending = $urandom_range(0, 2);
      case (ending)
         0: add_packet(16'($urandom_range(0, 3)), '0, '0, '0, '0, 1'b0);
         1: begin
            case ($urandom_range(0, 2))
               0: bad_len = 16'(MAX_PACKET + 1);
               1: bad_len = 16'hFFFF;
               default: bad_len = 16'($urandom_range(MAX_PACKET + 1, 65535));
            endcase
            add_packet(bad_len, '0, '0, '0, '0, 1'b0);
         end
         default: add_packet(16'($urandom_range(MIN_LEN, GOTO_MIN_LEN - 1)), GOTO_TYPE,
                             {$urandom, $urandom}, $urandom, $urandom, 1'b0);
      endcase
      // Trailing noise that must be dropped.
      repeat (24) push_byte(8'($urandom), {$urandom, $urandom}, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last byte to go in, then for the last event to come out.
      while (stream_bytes.size() != 0 || req_chan.valid) @(posedge clock);
      while (predicted_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/gpd_pkg.sv
rtl/gpd_stream_if.sv
rtl/gpd_parser.sv
rtl/goto_packet_deframer.sv
rtl/gpd_checker.sv
verif/tb.sv
